[rtl/tcw_pkg.sv]
// Shared constants and controller/datapath interface types for the text console cell writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [MODE_W-1:0] MODE_PUT_CHAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT_AT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'd7;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic clr_step;
    logic scr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scroll_req;
    logic clr_last;
    logic scr_last;
  } stat_t;

endpackage

[rtl/tcw_ram.sv]
// Generic RAM with separate write and read addresses and registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tcw_datapath.sv]
// Datapath: request registers, cursor, scroll base row, screen RAM and result register.
module tcw_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cmd_t               cmd,
  output tcw_pkg::stat_t              stat,
  input  logic                        text_color_we,
  input  logic [tcw_pkg::CHAR_W-1:0]  text_color_wdata,
  input  logic [tcw_pkg::MODE_W-1:0]  mode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]  attribute,
  input  logic [tcw_pkg::COL_W-1:0]   col_sel,
  input  logic [tcw_pkg::ROW_W-1:0]   row_sel,
  output logic [tcw_pkg::CELL_W-1:0]  cell_value,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row
);
  import tcw_pkg::*;

  logic [MODE_W-1:0] req_mode;
  logic [CHAR_W-1:0] req_char;
  logic [CHAR_W-1:0] req_attr;
  logic [COL_W-1:0]  req_col;
  logic [ROW_W-1:0]  req_row;
  logic [CHAR_W-1:0] text_color;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  base_row;
  logic [ROW_W-1:0]  scr_row;
  logic [COL_W-1:0]  scr_col;
  logic [ADDR_W-1:0] clr_addr;
  logic              rd_ok;

  logic              is_char;
  logic              is_nl;
  logic              sel_in_rng;
  logic              col_wrap;
  logic              row_last;
  logic [ROW_W-1:0]  log_row;
  logic [COL_W-1:0]  log_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  assign is_char    = (req_mode == MODE_PUT_CHAR);
  assign is_nl      = (req_char == NEWLINE_CODE);
  assign sel_in_rng = (req_col < COL_W'(COLUMNS)) && (req_row < ROW_W'(ROWS));
  assign col_wrap   = is_nl || (cur_col == COL_W'(COLUMNS - 1));
  assign row_last   = (cur_row == ROW_W'(ROWS - 1));

  assign stat.scroll_req = is_char && col_wrap && row_last;
  assign stat.clr_last   = (clr_addr == ADDR_W'(CELL_COUNT - 1));
  assign stat.scr_last   = (scr_col == COL_W'(COLUMNS - 1));

  // logical row to physical row through the circular base
  assign log_row  = is_char ? cur_row : req_row;
  assign log_col  = is_char ? cur_col : req_col;
  assign row_sum  = {1'b0, log_row} + {1'b0, base_row};
  assign phys_row = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                  : ROW_W'(row_sum);

  assign a_row     = cmd.scr_step ? scr_row : phys_row;
  assign a_col     = cmd.scr_step ? scr_col : log_col;
  assign cell_addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(COLUMNS)) + ADDR_W'(a_col);
  assign mem_addr  = cmd.clr_step ? clr_addr : cell_addr;

  assign mem_we = cmd.clr_step || cmd.scr_step ||
                  (cmd.exec && ((is_char && !is_nl) ||
                                ((req_mode == MODE_PUT_AT) && sel_in_rng)));
  assign mem_re = cmd.exec && (req_mode == MODE_READ) && sel_in_rng;

  always_comb begin
    if (cmd.clr_step) begin
      mem_wdata = {DEFAULT_ATTR, SPACE_CODE};
    end else if (cmd.scr_step) begin
      mem_wdata = '0;
    end else if (is_char) begin
      mem_wdata = {text_color, req_char};
    end else begin
      mem_wdata = {req_attr, req_char};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= DEFAULT_ATTR;
      cur_col    <= '0;
      cur_row    <= '0;
      base_row   <= '0;
      clr_addr   <= '0;
    end else begin
      if (text_color_we) begin
        text_color <= text_color_wdata;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.exec && is_char) begin
        if (col_wrap) begin
          cur_col <= '0;
          if (row_last) begin
            // scroll: rotate base, old top row becomes the new bottom row
            base_row <= (base_row == ROW_W'(ROWS - 1)) ? '0 : base_row + ROW_W'(1);
          end else begin
            cur_row <= cur_row + ROW_W'(1);
          end
        end else begin
          cur_col <= cur_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= mode;
      req_char <= char_code;
      req_attr <= attribute;
      req_col  <= col_sel;
      req_row  <= row_sel;
    end
    if (cmd.exec) begin
      rd_ok   <= mem_re;
      scr_row <= base_row;
      scr_col <= '0;
    end
    if (cmd.scr_step) begin
      scr_col <= scr_col + COL_W'(1);
    end
    if (cmd.out_load) begin
      cell_value <= rd_ok ? mem_rdata : '0;
      cursor_col <= cur_col;
      cursor_row <= cur_row;
    end
  end

endmodule

[rtl/tcw_ctrl.sv]
// Controller: sequences reset clearing, request execution, scroll row fill and result hand-off.
module tcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tcw_pkg::cmd_t  cmd,
  input  tcw_pkg::stat_t stat
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state == S_CLEAR);
    cmd.load_req = (state == S_IDLE) && in_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.scr_step = (state == S_SCROLL);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= stat.scroll_req ? S_SCROLL : S_DONE;
        end
        S_SCROLL: begin
          if (stat.scr_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

[rtl/text_console_cell_writer.sv]
// Text console cell writer: top level joining controller and datapath.
//
// Input channel in_valid/in_ready carries one request: mode (put char at
// cursor, put cell at position, read cell), char_code, attribute, col_sel,
// row_sel. Output channel out_valid/out_ready returns one result per request:
// cell_value (read data, else zero) and the cursor position after the request.
// text_color_we/text_color_wdata write the put-char attribute.
// A request goes from acceptance to result in these steps: accept, execute (RAM
// write or registered read), result load. in_ready returns the cycle after
// the result is loaded, so one request is in flight at a time. A put-char
// that moves past the last row rotates the row base and zero-fills the new
// bottom row, one RAM write per cell.
// After reset the screen RAM is filled with spaces in attribute 7, one cell
// a cycle: in_ready stays low until all ROWS*COLUMNS (2000) cells are written.
// The result register parts the two sides: the next request is accepted while
// a result waits; when the receiver stalls, a finished request holds in its
// last step until the result register frees.
module text_console_cell_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::MODE_W-1:0]  mode,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]  attribute,
  input  logic [tcw_pkg::COL_W-1:0]   col_sel,
  input  logic [tcw_pkg::ROW_W-1:0]   row_sel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::CELL_W-1:0]  cell_value,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  input  logic                        text_color_we,
  input  logic [tcw_pkg::CHAR_W-1:0]  text_color_wdata
);
  import tcw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcw_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .text_color_we    (text_color_we),
    .text_color_wdata (text_color_wdata),
    .mode             (mode),
    .char_code        (char_code),
    .attribute        (attribute),
    .col_sel          (col_sel),
    .row_sel          (row_sel),
    .cell_value       (cell_value),
    .cursor_col       (cursor_col),
    .cursor_row       (cursor_row)
  );

endmodule

[rtl/tcw_checker.sv]
// Port-level assertions for the text console cell writer, bound to the top level.
module tcw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcw_pkg::CELL_W-1:0]  cell_value,
  input logic [tcw_pkg::COL_W-1:0]   cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]   cursor_row
);
  import tcw_pkg::*;

  // screen clear runs after reset: nothing accepted, nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("request or result active right after reset");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is executing");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_col < COL_W'(COLUMNS)) && (cursor_row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      out_valid && $stable(cell_value) && $stable(cursor_col) && $stable(cursor_row))
    else $error("stalled result changed");

endmodule

bind text_console_cell_writer tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cell_value (cell_value),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row)
);
